### sv/bounded_random_range_reducer_assert.svh
// assertion macros for the bounded random range reducer checker
`ifndef BOUNDED_RANDOM_RANGE_REDUCER_ASSERT_SVH
`define BOUNDED_RANDOM_RANGE_REDUCER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BRR_ASSERT_NOW(lbl, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define BRR_ASSERT_NEXT(lbl, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/brr_pkg.sv
// shared constants and types for the bounded random range reducer
`timescale 1ns / 1ps
package brr_pkg;
  localparam logic [1:0] STATUS_VALID  = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_DOMAIN = 2'd2;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_POW2 = 2'd1,
    CLS_GEN  = 2'd2
  } cls_t;
endpackage

### sv/brr_front.sv
// front stage: masks the inputs to the word width and classifies the range
`timescale 1ns / 1ps
module brr_front #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      range_limit,
  input  logic [31:0]      random_word,
  output logic             f_valid,
  input  logic             f_ready,
  output logic [2*W+1:0]   f_data
);
  logic [W-1:0] rng;
  logic [W-1:0] wrd;
  logic [1:0]   cls;
  logic         full;

  assign in_ready = !full || f_ready;
  assign f_valid  = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
    if (in_valid && in_ready) begin
      rng <= range_limit[W-1:0];
      wrd <= random_word[W-1:0];
      if (range_limit[W-1:0] == '0) begin
        cls <= brr_pkg::CLS_ZERO;
      end else if ((range_limit[W-1:0] & (range_limit[W-1:0] - W'(1))) == '0) begin
        cls <= brr_pkg::CLS_POW2;
      end else begin
        cls <= brr_pkg::CLS_GEN;
      end
    end
  end

  assign f_data = {cls, rng, wrd};
endmodule

### sv/brr_queue.sv
// small fifo between the front and the back
`timescale 1ns / 1ps
module brr_queue #(
  parameter int DW = 66
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);
  logic [DW-1:0] mem [0:3];
  logic [1:0]    wptr;
  logic [1:0]    rptr;
  logic [2:0]    count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = count != 3'd4;
  assign rd_valid = count != 3'd0;
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 2'd1;
      if (do_rd) rptr <= rptr + 2'd1;
      count <= count + {2'b0, do_wr} - {2'b0, do_rd};
    end
    if (do_wr) mem[wptr] <= wr_data;
  end
endmodule

### sv/brr_back.sv
// back pipeline: product, one remainder bit per stage, final compare
`timescale 1ns / 1ps
module brr_back #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  logic [2*W+1:0] q_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     status,
  output logic [31:0]    bounded_value
);
  typedef struct packed {
    logic [1:0]     cls;
    logic [W-1:0]   rng;
    logic [W-1:0]   wrd;
    logic [W-1:0]   dvd;
    logic [W-1:0]   rem;
    logic [2*W-1:0] prod;
  } stg_t;

  stg_t stg [0:W];
  logic vld [0:W];
  logic advance;
  logic [1:0]   qc;
  logic [W-1:0] qr;
  logic [W-1:0] qw;

  assign advance = !out_valid || out_ready;
  assign q_ready = advance;
  assign {qc, qr, qw} = q_data;

  // one restoring remainder step of (2^W - range) mod range, msb first
  function automatic stg_t rem_stage(stg_t s, int k);
    stg_t       r;
    logic [W:0] trial;
    r = s;
    trial = {s.rem, s.dvd[W-k]};
    if (trial >= {1'b0, s.rng}) begin
      trial = trial - {1'b0, s.rng};
    end
    r.rem = trial[W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= W; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (advance) begin
      vld[0] <= q_valid;
      for (int k = 1; k <= W; k++) begin
        vld[k] <= vld[k-1];
      end
    end
    if (advance) begin
      stg[0].cls  <= qc;
      stg[0].rng  <= qr;
      stg[0].wrd  <= qw;
      stg[0].dvd  <= W'(0) - qr;
      stg[0].rem  <= '0;
      stg[0].prod <= {{W{1'b0}}, qw} * {{W{1'b0}}, qr};
      for (int k = 1; k <= W; k++) begin
        stg[k] <= rem_stage(stg[k-1], k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld[W];
    end
    if (advance) begin
      case (stg[W].cls)
        brr_pkg::CLS_ZERO: begin
          status        <= brr_pkg::STATUS_DOMAIN;
          bounded_value <= '0;
        end
        brr_pkg::CLS_POW2: begin
          status        <= brr_pkg::STATUS_VALID;
          bounded_value <= 32'(stg[W].wrd & (stg[W].rng - W'(1)));
        end
        default: begin
          if (stg[W].prod[W-1:0] < stg[W].rem) begin
            status        <= brr_pkg::STATUS_REJECT;
            bounded_value <= '0;
          end else begin
            status        <= brr_pkg::STATUS_VALID;
            bounded_value <= 32'(stg[W].prod[2*W-1:W]);
          end
        end
      endcase
    end
  end
endmodule

### sv/bounded_random_range_reducer.sv
// top level of the bounded random range reducer
// Maps a random word into [0, range_limit) without bias, one item per cycle
// sustained while the output is taken. Each item yields one result: status 0
// with the value, status 1 when the word must be replaced by a fresh one,
// status 2 for a zero range. An item is loaded into the front register when
// it is taken, then passes the fifo, the product register, one stage per
// remainder bit of the rejection threshold, and the output register. A
// four-item fifo between front and back lets either side stall alone. Only
// the low WORD_BITS bits of each input are used.
`timescale 1ns / 1ps
module bounded_random_range_reducer #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] range_limit,
  input  logic [31:0] random_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] bounded_value
);
  localparam int DW = 2 * WORD_BITS + 2;

  logic          f_valid;
  logic          f_ready;
  logic [DW-1:0] f_data;
  logic          q_valid;
  logic          q_ready;
  logic [DW-1:0] q_data;

  brr_front #(.W(WORD_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .range_limit, .random_word,
    .f_valid, .f_ready, .f_data
  );

  brr_queue #(.DW(DW)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  brr_back #(.W(WORD_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .status, .bounded_value
  );
endmodule

### sv/brr_checker.sv
// port-level checker for the bounded random range reducer, with its bind
`timescale 1ns / 1ps
`include "bounded_random_range_reducer_assert.svh"
module brr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] bounded_value
);
  `BRR_ASSERT_NOW(a_status_code, rst, out_valid, status != 2'd3)
  `BRR_ASSERT_NOW(a_value_zero, rst, out_valid && status != brr_pkg::STATUS_VALID, bounded_value == 32'd0)
  `BRR_ASSERT_NEXT(a_out_hold, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(bounded_value))
endmodule

bind bounded_random_range_reducer brr_checker u_brr_checker (
  .clk, .rst, .out_valid, .out_ready, .status, .bounded_value
);
